// ===== rtl/core/dvp_pkg.sv =====
// Shared constants and types for the dotted version triple parser.
package dvp_pkg;

   localparam int unsigned CHAR_W = 8;
   localparam int unsigned PART_W = 32;

   // Product of a part and ten, plus one digit, before the range check
   localparam int unsigned WIDE_W = PART_W + 4;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK            = 2'd0;
   localparam status_type STATUS_NOT_CANONICAL = 2'd1;
   localparam status_type STATUS_OVERFLOW      = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

   // Dots counted before the third part
   localparam logic [1:0] LAST_PART_INDEX = 2'd2;
   // Digit count saturates here
   localparam logic [1:0] LENGTH_MAX = 2'd2;

endpackage

// ===== rtl/core/dvp_req_if.sv =====
// Character channel: one byte of the version string per word.
interface dvp_req_if;
   logic                        valid;
   logic                        ready;
   logic [dvp_pkg::CHAR_W-1:0] char_code;
   logic                        is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ===== rtl/core/dvp_rsp_if.sv =====
// Result channel: parsed major, minor, patch and status per word.
interface dvp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dvp_pkg::PART_W-1:0] major_part;
   logic [dvp_pkg::PART_W-1:0] minor_part;
   logic [dvp_pkg::PART_W-1:0] patch_part;
   dvp_pkg::status_type         status;

   modport source (output valid, output major_part, output minor_part,
                   output patch_part, output status, input ready);
   modport sink   (input valid, input major_part, input minor_part,
                   input patch_part, input status, output ready);
endinterface

// ===== rtl/core/dotted_version_triple_parser_core.sv =====
// Top level: streaming parser of a major.minor.patch version string.
//
//   channel  | dir | word contents                               | handshake
//   ---------+-----+---------------------------------------------+-----------
//   req_ch   | in  | char_code, is_last                          | valid/ready
//   rsp_ch   | out | major_part, minor_part, patch_part, status  | valid/ready
//
// One character per cycle, but a last character waits for a free result word.
// A character is held in the input register, then one add-and-compare step
// updates the parse state; a last character then also loads the result register.
// Reset (synchronous) clears the parse state and both valid flags.
// A stalled result holds only the last character of the next string; other
// characters keep flowing while the result waits.
module dotted_version_triple_parser_core (
   input  logic            clock,
   input  logic            reset,
   dvp_req_if.sink         req_ch,
   dvp_rsp_if.source       rsp_ch
);

   localparam int unsigned CW = dvp_pkg::CHAR_W;
   localparam int unsigned PW = dvp_pkg::PART_W;
   localparam int unsigned WW = dvp_pkg::WIDE_W;

   // Input register
   logic          s1_valid_ff, s1_valid_in;
   logic [CW-1:0] s1_char_ff;
   logic          s1_last_ff;

   // Parse state
   logic [1:0]          part_index_ff, part_index_in;
   logic [PW-1:0]       accumulator_ff, accumulator_in;
   logic [PW-1:0]       held_major_ff, held_major_in;
   logic [PW-1:0]       held_minor_ff, held_minor_in;
   logic [1:0]          part_length_ff, part_length_in;
   logic                starts_zero_ff, starts_zero_in;
   logic                extra_dot_ff, extra_dot_in;
   dvp_pkg::status_type first_error_ff, first_error_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]       rsp_major_ff, rsp_major_in;
   logic [PW-1:0]       rsp_minor_ff, rsp_minor_in;
   logic [PW-1:0]       rsp_patch_ff, rsp_patch_in;
   dvp_pkg::status_type rsp_status_ff, rsp_status_in;

   logic          out_free;
   logic          s1_go;
   logic          take_req;
   logic          is_digit;
   logic          is_dot;
   logic [3:0]    digit;
   logic [WW-1:0] wide_acc;
   logic [WW-1:0] wide_next;
   logic          overflow;
   dvp_pkg::status_type final_error;
   dvp_pkg::status_type final_status;

   // Advance the input register; only a last character waits on the result side
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_go        = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign take_req     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = take_req || (s1_valid_ff && !s1_go);

   // Classify the character and form ten times the part plus the digit
   assign is_digit  = (s1_char_ff >= dvp_pkg::CHAR_ZERO) &&
                      (s1_char_ff <= dvp_pkg::CHAR_NINE);
   assign is_dot    = (s1_char_ff == dvp_pkg::CHAR_DOT);
   assign digit     = s1_char_ff[3:0];
   assign wide_acc  = {{(WW-PW){1'b0}}, accumulator_ff};
   assign wide_next = (wide_acc << 3) + (wide_acc << 1) + {{(WW-4){1'b0}}, digit};
   assign overflow  = |wide_next[WW-1:PW];

   // Update the parse state for one character
   always_comb begin
      part_index_in  = part_index_ff;
      accumulator_in = accumulator_ff;
      held_major_in  = held_major_ff;
      held_minor_in  = held_minor_ff;
      part_length_in = part_length_ff;
      starts_zero_in = starts_zero_ff;
      extra_dot_in   = extra_dot_ff;
      first_error_in = first_error_ff;

      if (is_digit) begin
         if (first_error_ff == dvp_pkg::STATUS_OK) begin
            priority if ((part_length_ff != 2'd0) && starts_zero_ff) begin
               first_error_in = dvp_pkg::STATUS_NOT_CANONICAL;
            end else if (overflow) begin
               first_error_in = dvp_pkg::STATUS_OVERFLOW;
            end else begin
               accumulator_in = wide_next[PW-1:0];
               if ((part_length_ff == 2'd0) && (digit == 4'd0)) begin
                  starts_zero_in = 1'b1;
               end
               if (part_length_ff != dvp_pkg::LENGTH_MAX) begin
                  part_length_in = part_length_ff + 2'd1;
               end
            end
         end
      end else if (is_dot) begin
         if (part_index_ff == dvp_pkg::LAST_PART_INDEX) begin
            extra_dot_in = 1'b1;
         end else begin
            if ((part_length_ff == 2'd0) && (first_error_ff == dvp_pkg::STATUS_OK)) begin
               first_error_in = dvp_pkg::STATUS_NOT_CANONICAL;
            end
            if (part_index_ff == 2'd0) begin
               held_major_in = accumulator_ff;
            end else begin
               held_minor_in = accumulator_ff;
            end
            part_index_in  = part_index_ff + 2'd1;
            accumulator_in = '0;
            part_length_in = 2'd0;
            starts_zero_in = 1'b0;
         end
      end else if (first_error_ff == dvp_pkg::STATUS_OK) begin
         first_error_in = dvp_pkg::STATUS_NOT_CANONICAL;
      end
   end

   // Close the string: empty last part, then dot count overrides everything
   always_comb begin
      final_error = first_error_in;
      if ((part_length_in == 2'd0) && (final_error == dvp_pkg::STATUS_OK)) begin
         final_error = dvp_pkg::STATUS_NOT_CANONICAL;
      end
      if ((part_index_in != dvp_pkg::LAST_PART_INDEX) || extra_dot_in) begin
         final_status = dvp_pkg::STATUS_NOT_CANONICAL;
      end else begin
         final_status = final_error;
      end
   end

   // Load the result word on the last character, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_major_in  = rsp_major_ff;
      rsp_minor_in  = rsp_minor_ff;
      rsp_patch_in  = rsp_patch_ff;
      rsp_status_in = rsp_status_ff;
      if (s1_go && s1_last_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = final_status;
         if (final_status == dvp_pkg::STATUS_OK) begin
            rsp_major_in = held_major_in;
            rsp_minor_in = held_minor_in;
            rsp_patch_in = accumulator_in;
         end else begin
            rsp_major_in = '0;
            rsp_minor_in = '0;
            rsp_patch_in = '0;
         end
      end
   end

   // Hold control and parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         part_index_ff  <= 2'd0;
         accumulator_ff <= '0;
         held_major_ff  <= '0;
         held_minor_ff  <= '0;
         part_length_ff <= 2'd0;
         starts_zero_ff <= 1'b0;
         extra_dot_ff   <= 1'b0;
         first_error_ff <= dvp_pkg::STATUS_OK;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            if (s1_last_ff) begin
               part_index_ff  <= 2'd0;
               accumulator_ff <= '0;
               held_major_ff  <= '0;
               held_minor_ff  <= '0;
               part_length_ff <= 2'd0;
               starts_zero_ff <= 1'b0;
               extra_dot_ff   <= 1'b0;
               first_error_ff <= dvp_pkg::STATUS_OK;
            end else begin
               part_index_ff  <= part_index_in;
               accumulator_ff <= accumulator_in;
               held_major_ff  <= held_major_in;
               held_minor_ff  <= held_minor_in;
               part_length_ff <= part_length_in;
               starts_zero_ff <= starts_zero_in;
               extra_dot_ff   <= extra_dot_in;
               first_error_ff <= first_error_in;
            end
         end
      end
   end

   // Hold payload words
   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_char_ff <= req_ch.char_code;
         s1_last_ff <= req_ch.is_last;
      end
      rsp_major_ff  <= rsp_major_in;
      rsp_minor_ff  <= rsp_minor_in;
      rsp_patch_ff  <= rsp_patch_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.major_part = rsp_major_ff;
   assign rsp_ch.minor_part = rsp_minor_ff;
   assign rsp_ch.patch_part = rsp_patch_ff;
   assign rsp_ch.status     = rsp_status_ff;

endmodule

// ===== rtl/core/dvp_checker.sv =====
// Port-level checks for the version parser, bound to the top level.
module dvp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [dvp_pkg::PART_W-1:0] rsp_major_part,
   input logic [dvp_pkg::PART_W-1:0] rsp_minor_part,
   input logic [dvp_pkg::PART_W-1:0] rsp_patch_part,
   input dvp_pkg::status_type         rsp_status
);

   // No result word is left over from before reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // Status is one of the three defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == dvp_pkg::STATUS_OK ||
                     rsp_status == dvp_pkg::STATUS_NOT_CANONICAL ||
                     rsp_status == dvp_pkg::STATUS_OVERFLOW))
      else $error("undefined status code");

   // A failed parse reports all parts as zero
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != dvp_pkg::STATUS_OK) |->
         (rsp_major_part == '0 && rsp_minor_part == '0 && rsp_patch_part == '0))
      else $error("nonzero part on failed parse");

   // A stalled result word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_major_part) &&
          $stable(rsp_minor_part) && $stable(rsp_patch_part)))
      else $error("result word changed while stalled");

endmodule

bind dotted_version_triple_parser_core dvp_checker u_dvp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_major_part (rsp_ch.major_part),
   .rsp_minor_part (rsp_ch.minor_part),
   .rsp_patch_part (rsp_ch.patch_part),
   .rsp_status     (rsp_ch.status)
);

// ===== bench/version_triple_checker.sv =====
`timescale 1ns / 1ps
// Checker for the version parser: predicts each result word from the characters and compares.
module version_triple_checker
   import dvp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              char_valid,
   input  logic              char_ready,
   input  logic [CHAR_W-1:0] char_code,
   input  logic              char_last,
   input  logic              triple_valid,
   input  logic              triple_ready,
   input  logic [PART_W-1:0] major_part,
   input  logic [PART_W-1:0] minor_part,
   input  logic [PART_W-1:0] patch_part,
   input  status_type        status,
   output int                triples_due,
   output int                mismatch_count
);

   localparam int DECIMAL_BASE = 10;

   typedef struct packed {
      logic [PART_W-1:0] major;
      logic [PART_W-1:0] minor;
      logic [PART_W-1:0] patch;
      status_type        status;
   } triple_t;

   // Parse state of the string in flight
   logic [1:0]        dots_seen;
   logic [PART_W-1:0] part_value;
   logic [PART_W-1:0] major_held;
   logic [PART_W-1:0] minor_held;
   logic [1:0]        digit_count;
   logic              zero_lead;
   logic              dot_surplus;
   status_type        parse_error;

   triple_t triple_q[$];
   int      mismatches;

   task automatic clear_parse();
      dots_seen   = 2'd0;
      part_value  = '0;
      major_held  = '0;
      minor_held  = '0;
      digit_count = 2'd0;
      zero_lead   = 1'b0;
      dot_surplus = 1'b0;
      parse_error = STATUS_OK;
   endtask

   // Keep only the first error of the string
   task automatic note_fault(input status_type code);
      if (parse_error == STATUS_OK) parse_error = code;
   endtask

   // Advance the parse by one character; queue a result word on the last one
   task automatic parse_char(input logic [CHAR_W-1:0] code, input logic last);
      logic [WIDE_W-1:0] scaled;
      triple_t           verdict;
      if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
         if (parse_error == STATUS_OK) begin
            if (digit_count != 2'd0 && zero_lead) begin
               parse_error = STATUS_NOT_CANONICAL;
            end else begin
               scaled = WIDE_W'(part_value) * WIDE_W'(DECIMAL_BASE)
                        + WIDE_W'(code - CHAR_ZERO);
               if (scaled[WIDE_W-1:PART_W] != '0) begin
                  parse_error = STATUS_OVERFLOW;
               end else begin
                  part_value = scaled[PART_W-1:0];
                  if (digit_count == 2'd0 && code == CHAR_ZERO) zero_lead = 1'b1;
                  if (digit_count < LENGTH_MAX) digit_count++;
               end
            end
         end
      end else if (code == CHAR_DOT) begin
         // dots past the second only mark the string as bad
         if (dots_seen >= LAST_PART_INDEX) begin
            dot_surplus = 1'b1;
         end else begin
            if (digit_count == 2'd0) note_fault(STATUS_NOT_CANONICAL);
            if (dots_seen == 2'd0) major_held = part_value;
            else minor_held = part_value;
            dots_seen++;
            part_value  = '0;
            digit_count = 2'd0;
            zero_lead   = 1'b0;
         end
      end else begin
         note_fault(STATUS_NOT_CANONICAL);
      end

      if (last) begin
         if (digit_count == 2'd0) note_fault(STATUS_NOT_CANONICAL);
         verdict = '0;
         // a wrong dot count overrides any other error
         if (dots_seen != LAST_PART_INDEX || dot_surplus) verdict.status = STATUS_NOT_CANONICAL;
         else verdict.status = parse_error;
         if (verdict.status == STATUS_OK) begin
            verdict.major = major_held;
            verdict.minor = minor_held;
            verdict.patch = part_value;
         end
         triple_q.push_back(verdict);
         clear_parse();
      end
   endtask

   function automatic void compare_field(input string field, input logic [PART_W-1:0] want,
                                         input logic [PART_W-1:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0d, got %0d", field, want, seen);
         mismatches++;
      end
   endfunction

   // Compare the returned word first, then queue any new prediction
   always @(posedge clock) begin
      triple_t want;
      if (reset) begin
         clear_parse();
         triple_q.delete();
      end else begin
         if (triple_valid && triple_ready) begin
            if (triple_q.size() == 0) begin
               $error("result word with no string pending: status %0d", status);
               mismatches++;
            end else begin
               want = triple_q.pop_front();
               compare_field("major_part", want.major, major_part);
               compare_field("minor_part", want.minor, minor_part);
               compare_field("patch_part", want.patch, patch_part);
               compare_field("status", PART_W'(want.status), PART_W'(status));
            end
         end
         if (char_valid && char_ready) parse_char(char_code, char_last);
      end
      triples_due    <= triple_q.size();
      mismatch_count <= mismatches;
   end

endmodule

// ===== bench/tb_dotted_version_triple_parser_core.sv =====
`timescale 1ns / 1ps
// Testbench top: feeds version strings to the parser core and gives the verdict.
module tb_dotted_version_triple_parser_core;
   import dvp_pkg::*;

   localparam int CHAR_TARGET  = 1900;
   localparam int CALM_TAIL    = 300;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 16;

   logic clock = 1'b0;
   logic reset;
   logic send_idle;
   logic sink_idle;
   int   sink_hold;
   int   quiet_cycles;
   int   triples_due;
   int   mismatch_count;
   int   sent_chars;

   logic [CHAR_W-1:0] text_q[$];

   dvp_req_if req_ch();
   dvp_rsp_if rsp_ch();

   dotted_version_triple_parser_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   version_triple_checker triple_check (
      .clock          (clock),
      .reset          (reset),
      .char_valid     (req_ch.valid),
      .char_ready     (req_ch.ready),
      .char_code      (req_ch.char_code),
      .char_last      (req_ch.is_last),
      .triple_valid   (rsp_ch.valid),
      .triple_ready   (rsp_ch.ready),
      .major_part     (rsp_ch.major_part),
      .minor_part     (rsp_ch.minor_part),
      .patch_part     (rsp_ch.patch_part),
      .status         (rsp_ch.status),
      .triples_due    (triples_due),
      .mismatch_count (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result side in bursts, always with at least one ready cycle between them
   always @(posedge clock) begin
      if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
         if (sink_hold == 1) rsp_ch.ready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
         rsp_ch.ready <= 1'b0;
         sink_hold    <= $urandom_range(1, 17);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Drop the run when no word moves on either channel for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Hold one character on the channel until it is taken
   task automatic send_char(input logic [CHAR_W-1:0] code, input logic last);
      if (send_idle && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= code;
      req_ch.is_last   <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_queued();
      for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
      sent_chars += text_q.size();
      text_q.delete();
   endtask

   task automatic push_text(input string line);
      for (int i = 0; i < line.len(); i++) text_q.push_back(line[i]);
   endtask

   // Stop sending and hold until every result word is back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (triples_due != 0) @(posedge clock);
   endtask

   // One random part: mostly legal numbers, some overflowing, zero-led or empty
   function automatic string random_part();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return $sformatf("%0d", $urandom_range(0, 999));
      if (pick < 60) return $sformatf("%0d", $urandom());
      if (pick < 70) return $sformatf("%0d", 32'hFFFF_FFFF - $urandom_range(0, 20));
      if (pick < 78) return $sformatf("%0d", 33'h1_0000_0000 + $urandom_range(0, 20));
      if (pick < 84) return $sformatf("%0d%0d", $urandom_range(1, 999), $urandom());
      if (pick < 92) return {"0", $sformatf("%0d", $urandom_range(0, 99))};
      if (pick < 96) return "0";
      return "";
   endfunction

   function automatic logic [CHAR_W-1:0] random_byte();
      case ($urandom_range(0, 3))
         0:       return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
         1:       return CHAR_DOT;
         default: return CHAR_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Build one string: mostly three-part versions, some with wrong dot counts,
   // some with a corrupted byte, and some plain noise
   task automatic build_version();
      int unsigned pick;
      int unsigned parts;
      int unsigned spot;
      string       line;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         repeat ($urandom_range(1, 6)) text_q.push_back(random_byte());
      end else begin
         parts = 3;
         if (pick < 16) parts = $urandom_range(1, 2);
         else if (pick < 22) parts = $urandom_range(4, 5);
         line = random_part();
         for (int p = 1; p < parts; p++) line = {line, ".", random_part()};
         push_text(line);
         if (pick >= 22 && pick < 30 && text_q.size() != 0) begin
            spot = $urandom_range(0, text_q.size() - 1);
            if ($urandom_range(0, 1) == 0) text_q.insert(spot, CHAR_W'($urandom_range(0, 255)));
            else text_q[spot] = CHAR_W'($urandom_range(0, 255));
         end
      end
      // never present an empty string
      if (text_q.size() == 0) text_q.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
   endtask

   initial begin
      string probes[0:16] = '{
         "0.0.0",
         "4294967295.4294967295.4294967295",
         "4294967296.0.0",
         "10.20.300",
         "01.2.3",
         "1.00.3",
         ".1.2",
         "1..2",
         "1.2.",
         "1.2",
         "1.2.3.4",
         "1.a.9",
         "7",
         "9999999999.1",
         "1.x.99999999999",
         "1.99999999999.z",
         "."
      };
      logic calm;
      logic paused_mid;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      req_ch.is_last   = 1'b0;
      rsp_ch.ready     = 1'b0;
      send_idle        = 1'b0;
      sink_idle        = 1'b0;
      sink_hold        = 0;
      quiet_cycles     = 0;
      sent_chars       = 0;
      paused_mid       = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed strings: edge values, each error kind, precedence of errors
      foreach (probes[i]) begin
         send_idle = (i % 2 == 1);
         sink_idle <= (i % 3 == 0);
         push_text(probes[i]);
         send_queued();
      end
      wait_drained();

      // random strings, quiet on both sides for the tail of the run
      while (sent_chars < CHAR_TARGET) begin
         calm = (sent_chars >= CHAR_TARGET - CALM_TAIL);
         send_idle = !calm && ($urandom_range(0, 3) != 0);
         sink_idle <= !calm && ($urandom_range(0, 3) != 0);
         build_version();
         send_queued();
         if (!paused_mid && sent_chars >= CHAR_TARGET / 2) begin
            wait_drained();
            paused_mid = 1'b1;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
